[rtl/damped_spring_force_2d_macros.svh]
// Assertion macros used by the port-level checker of the damped spring block.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef DAMPED_SPRING_FORCE_2D_MACROS_SVH
`define DAMPED_SPRING_FORCE_2D_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define DSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define DSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dsf_pkg.sv]
// Shared widths, payload structs, register indexes and reset values of the
// damped spring force block. Depends on nothing.
package dsf_pkg;

  localparam int FRAC = 16;             // fraction bits of all fixed point values
  localparam int DW   = 33;             // width of a coordinate difference
  localparam int SQW  = 2 * DW;         // sum of squares
  localparam int RW   = DW + 1;         // square root result bits
  localparam int TW   = 2 * RW;         // root trial width
  localparam int QW   = FRAC + 1;       // direction magnitude bits
  localparam int CW   = RW + QW;        // divider remainder width
  localparam int UW   = QW + 1;         // signed direction component
  localparam int PW   = UW + DW;        // velocity projection product
  localparam int XSW  = RW + 1;         // signed stretch
  localparam int VW   = PW + 1 - FRAC;  // projected speed magnitude
  localparam int KW   = 32;             // coefficient width
  localparam int TKW  = RW + KW;        // spring term
  localparam int TDW  = VW + KW;        // damping term
  localparam int SW   = TDW + 2;        // signed scalar sum
  localparam int MW   = SW - FRAC;      // scalar magnitude after scaling
  localparam int FW   = MW + QW;        // force product
  localparam int FMW  = FW - FRAC;      // force magnitude after scaling

  localparam longint DAMP_RESET_L = ((64'd20115 << FRAC) + 64'd50000) / 64'd100000;
  localparam logic [30:0] REST_RESET  = 31'(64'd1 << FRAC);
  localparam logic [31:0] STIFF_RESET = 32'(64'd40 << FRAC);
  localparam logic [31:0] DAMP_RESET  = 32'(DAMP_RESET_L);

  typedef enum logic [1:0] {
    CFG_REST_LENGTH = 2'd0,
    CFG_STIFFNESS   = 2'd1,
    CFG_DAMPING     = 2'd2
  } dsf_cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
  } dsf_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               zero_length;
    logic               saturated;
  } dsf_out_t;

  // Side data that rides along the root and divide stages.
  typedef struct packed {
    logic                 sx;
    logic                 sy;
    logic [DW-1:0]        ax;
    logic [DW-1:0]        ay;
    logic signed [DW-1:0] rvx;
    logic signed [DW-1:0] rvy;
  } dsf_tag_t;

endpackage

[rtl/damped_spring_force_2d.sv]
// Damped 2D spring force: one spring evaluation enters per cycle and its force
// on the first end leaves through the front end, the 34-stage square root, the
// 17-stage direction dividers (each stage resolving one bit) and the back end.
// When the output is stalled the whole pipeline holds and in_ready drops. The
// user writes registers through cfg_* only while no spring is in flight; the
// block does not enforce this. Uses dsf_pkg and dsf_root_div.
module damped_spring_force_2d (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dsf_pkg::dsf_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dsf_pkg::dsf_out_t out_data,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);
  import dsf_pkg::*;

  logic        adv;
  logic [30:0] rest_r;
  logic [31:0] stiff_r;
  logic [31:0] damp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r  <= REST_RESET;
      stiff_r <= STIFF_RESET;
      damp_r  <= DAMP_RESET;
    end else if (cfg_wr_en) begin
      unique case (dsf_cfg_idx_t'(cfg_index))
        CFG_REST_LENGTH: rest_r  <= cfg_wdata[30:0];
        CFG_STIFFNESS:   stiff_r <= cfg_wdata;
        CFG_DAMPING:     damp_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  dsf_out_t out_data_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Front end: differences, magnitudes, squares, sum of squares.
  logic v0_r, v1_r, v2_r, v3_r;
  logic signed [DW-1:0] dx0_r, dy0_r, rvx0_r, rvy0_r;
  logic signed [DW-1:0] rvx1_r, rvy1_r;
  logic [DW-1:0] ax1_r, ay1_r;
  logic sx1_r, sy1_r;
  logic [SQW-1:0] axsq2_r, aysq2_r, sum3_r;
  dsf_tag_t tag2_r, tag3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx0_r  <= {in_data.second_pos_x[31], in_data.second_pos_x}
              - {in_data.first_pos_x[31], in_data.first_pos_x};
      dy0_r  <= {in_data.second_pos_y[31], in_data.second_pos_y}
              - {in_data.first_pos_y[31], in_data.first_pos_y};
      rvx0_r <= {in_data.second_vel_x[31], in_data.second_vel_x}
              - {in_data.first_vel_x[31], in_data.first_vel_x};
      rvy0_r <= {in_data.second_vel_y[31], in_data.second_vel_y}
              - {in_data.first_vel_y[31], in_data.first_vel_y};

      sx1_r  <= dx0_r[DW-1];
      sy1_r  <= dy0_r[DW-1];
      ax1_r  <= dx0_r[DW-1] ? DW'(-dx0_r) : DW'(dx0_r);
      ay1_r  <= dy0_r[DW-1] ? DW'(-dy0_r) : DW'(dy0_r);
      rvx1_r <= rvx0_r;
      rvy1_r <= rvy0_r;

      axsq2_r    <= SQW'(ax1_r) * SQW'(ax1_r);
      aysq2_r    <= SQW'(ay1_r) * SQW'(ay1_r);
      tag2_r.sx  <= sx1_r;
      tag2_r.sy  <= sy1_r;
      tag2_r.ax  <= ax1_r;
      tag2_r.ay  <= ay1_r;
      tag2_r.rvx <= rvx1_r;
      tag2_r.rvy <= rvy1_r;

      sum3_r <= axsq2_r + aysq2_r;
      tag3_r <= tag2_r;
    end
  end

  logic          vr;
  logic [RW-1:0] len_rd;
  logic [QW-1:0] qx_rd, qy_rd;
  dsf_tag_t      tag_rd;

  dsf_root_div u_root_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v3_r),
    .in_sum    (sum3_r),
    .in_tag    (tag3_r),
    .out_valid (vr),
    .out_len   (len_rd),
    .out_qx    (qx_rd),
    .out_qy    (qy_rd),
    .out_tag   (tag_rd)
  );

  // Back end: signed direction, projection, spring and damping terms, force.
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  logic zla_r, zlb_r, zlc_r, zld_r, zle_r, zlf_r;
  logic [QW-1:0] uxm_a_r, uym_a_r, uxm_b_r, uym_b_r, uxm_c_r, uym_c_r;
  logic [QW-1:0] uxm_d_r, uym_d_r, uxm_e_r, uym_e_r;
  logic uxn_a_r, uyn_a_r, uxn_b_r, uyn_b_r, uxn_c_r, uyn_c_r;
  logic uxn_d_r, uyn_d_r, uxn_e_r, uyn_e_r;
  logic signed [UW-1:0] ux_a_r, uy_a_r;
  logic [RW-1:0] len_a_r;
  logic signed [DW-1:0] rvx_a_r, rvy_a_r;
  logic signed [PW-1:0] px_b_r, py_b_r;
  logic signed [XSW-1:0] x_b_r;
  logic [VW-1:0] vmag_c_r;
  logic vneg_c_r, xneg_c_r, xneg_d_r, vneg_d_r;
  logic [RW-1:0] xmag_c_r;
  logic [TKW-1:0] tk_d_r;
  logic [TDW-1:0] td_d_r;
  logic [MW-1:0] smag_e_r;
  logic sneg_e_r;
  logic [FMW-1:0] fxm_f_r, fym_f_r;
  logic negx_f_r, negy_f_r;

  logic signed [UW-1:0] ux_nxt, uy_nxt;
  logic signed [PW-1:0] px_nxt, py_nxt;
  logic signed [XSW-1:0] x_nxt;
  logic signed [PW:0] psum;
  logic [PW:0] pabs;
  logic [RW-1:0] xabs;
  logic signed [SW-1:0] sk, sd, ssum;
  logic [SW-1:0] sabs;
  logic [FW-1:0] fx_full, fy_full;
  logic zl_nxt;

  assign zl_nxt = len_rd == '0;

  always_comb begin
    ux_nxt = $signed({1'b0, qx_rd});
    uy_nxt = $signed({1'b0, qy_rd});
    if (tag_rd.sx) ux_nxt = -ux_nxt;
    if (tag_rd.sy) uy_nxt = -uy_nxt;
    if (zl_nxt) begin
      ux_nxt = $signed(UW'(1) << FRAC);
      uy_nxt = '0;
    end
  end

  assign px_nxt = ux_a_r * rvx_a_r;
  assign py_nxt = uy_a_r * rvy_a_r;
  assign x_nxt  = $signed({1'b0, len_a_r}) - $signed(XSW'(rest_r));

  assign psum = (PW+1)'(px_b_r) + (PW+1)'(py_b_r);
  assign pabs = psum[PW] ? (PW+1)'(-psum) : (PW+1)'(psum);
  assign xabs = x_b_r[XSW-1] ? RW'(-x_b_r) : RW'(x_b_r);

  // Scalar = stiffness * stretch + damping * stretch rate, signed.
  assign sk   = xneg_d_r ? -$signed(SW'(tk_d_r)) : $signed(SW'(tk_d_r));
  assign sd   = vneg_d_r ? -$signed(SW'(td_d_r)) : $signed(SW'(td_d_r));
  assign ssum = sk + sd;
  assign sabs = ssum[SW-1] ? SW'(-ssum) : SW'(ssum);

  assign fx_full = FW'(smag_e_r) * FW'(uxm_e_r);
  assign fy_full = FW'(smag_e_r) * FW'(uym_e_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (adv) begin
      va_r <= vr;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zla_r   <= zl_nxt;
      ux_a_r  <= ux_nxt;
      uy_a_r  <= uy_nxt;
      uxm_a_r <= zl_nxt ? (QW'(1) << FRAC) : qx_rd;
      uym_a_r <= zl_nxt ? '0 : qy_rd;
      uxn_a_r <= !zl_nxt && tag_rd.sx;
      uyn_a_r <= !zl_nxt && tag_rd.sy;
      len_a_r <= len_rd;
      rvx_a_r <= tag_rd.rvx;
      rvy_a_r <= tag_rd.rvy;

      zlb_r   <= zla_r;
      px_b_r  <= px_nxt;
      py_b_r  <= py_nxt;
      x_b_r   <= x_nxt;
      uxm_b_r <= uxm_a_r;
      uym_b_r <= uym_a_r;
      uxn_b_r <= uxn_a_r;
      uyn_b_r <= uyn_a_r;

      zlc_r    <= zlb_r;
      vneg_c_r <= psum[PW];
      vmag_c_r <= pabs[PW:FRAC];
      xneg_c_r <= x_b_r[XSW-1];
      xmag_c_r <= xabs;
      uxm_c_r  <= uxm_b_r;
      uym_c_r  <= uym_b_r;
      uxn_c_r  <= uxn_b_r;
      uyn_c_r  <= uyn_b_r;

      zld_r    <= zlc_r;
      tk_d_r   <= TKW'(xmag_c_r) * TKW'(stiff_r);
      td_d_r   <= TDW'(vmag_c_r) * TDW'(damp_r);
      xneg_d_r <= xneg_c_r;
      vneg_d_r <= vneg_c_r;
      uxm_d_r  <= uxm_c_r;
      uym_d_r  <= uym_c_r;
      uxn_d_r  <= uxn_c_r;
      uyn_d_r  <= uyn_c_r;

      zle_r    <= zld_r;
      sneg_e_r <= ssum[SW-1];
      smag_e_r <= sabs[SW-1:FRAC];
      uxm_e_r  <= uxm_d_r;
      uym_e_r  <= uym_d_r;
      uxn_e_r  <= uxn_d_r;
      uyn_e_r  <= uyn_d_r;

      zlf_r    <= zle_r;
      fxm_f_r  <= fx_full[FW-1:FRAC];
      fym_f_r  <= fy_full[FW-1:FRAC];
      negx_f_r <= sneg_e_r ^ uxn_e_r;
      negy_f_r <= sneg_e_r ^ uyn_e_r;
    end
  end

  // Saturation to 32 bits; a zero magnitude is never negative.
  localparam logic [FMW-1:0] POS_LIM = FMW'(32'h7fff_ffff);
  localparam logic [FMW-1:0] NEG_LIM = FMW'(32'h8000_0000);

  logic        nx, ny, clipx, clipy;
  logic [31:0] mx, my;

  always_comb begin
    nx    = negx_f_r && (fxm_f_r != '0);
    ny    = negy_f_r && (fym_f_r != '0);
    clipx = fxm_f_r > (nx ? NEG_LIM : POS_LIM);
    clipy = fym_f_r > (ny ? NEG_LIM : POS_LIM);
    mx    = clipx ? 32'((nx ? NEG_LIM : POS_LIM)) : fxm_f_r[31:0];
    my    = clipy ? 32'((ny ? NEG_LIM : POS_LIM)) : fym_f_r[31:0];
    if (nx) mx = -mx;
    if (ny) my = -my;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.force_x     <= $signed(mx);
      out_data_r.force_y     <= $signed(my);
      out_data_r.zero_length <= zlf_r;
      out_data_r.saturated   <= clipx || clipy;
    end
  end

endmodule

[rtl/dsf_root_div.sv]
// Pipelined square root (one result bit per stage) followed by two pipelined
// restoring dividers that form the unit direction magnitudes. Uses dsf_pkg.
module dsf_root_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [dsf_pkg::SQW-1:0] in_sum,
  input  dsf_pkg::dsf_tag_t in_tag,
  output logic              out_valid,
  output logic [dsf_pkg::RW-1:0] out_len,
  output logic [dsf_pkg::QW-1:0] out_qx,
  output logic [dsf_pkg::QW-1:0] out_qy,
  output dsf_pkg::dsf_tag_t out_tag
);
  import dsf_pkg::*;

  logic           vs     [RW+1];
  logic [SQW-1:0] rem_s  [RW+1];
  logic [RW-1:0]  root_s [RW+1];
  dsf_tag_t       tag_s  [RW+1];

  assign vs[0]     = in_valid;
  assign rem_s[0]  = in_sum;
  assign root_s[0] = '0;
  assign tag_s[0]  = in_tag;

  // Each stage decides one root bit from the running remainder s - r*r.
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic [TW-1:0] trial;
    logic          ge;

    assign trial = (TW'(root_s[k]) << (B + 1)) | (TW'(1) << (2 * B));
    assign ge    = TW'(rem_s[k]) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs[k+1] <= 1'b0;
      end else if (adv) begin
        vs[k+1] <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[k+1]  <= ge ? SQW'(TW'(rem_s[k]) - trial) : rem_s[k];
        root_s[k+1] <= ge ? (root_s[k] | (RW'(1) << B)) : root_s[k];
        tag_s[k+1]  <= tag_s[k];
      end
    end
  end

  logic          vd    [QW+1];
  logic [RW-1:0] len_d [QW+1];
  logic [CW-1:0] rx_d  [QW+1];
  logic [CW-1:0] ry_d  [QW+1];
  logic [QW-1:0] qx_d  [QW+1];
  logic [QW-1:0] qy_d  [QW+1];
  dsf_tag_t      tag_d [QW+1];

  assign vd[0]    = vs[RW];
  assign len_d[0] = root_s[RW];
  assign rx_d[0]  = CW'(tag_s[RW].ax) << FRAC;
  assign ry_d[0]  = CW'(tag_s[RW].ay) << FRAC;
  assign qx_d[0]  = '0;
  assign qy_d[0]  = '0;
  assign tag_d[0] = tag_s[RW];

  // Since each magnitude is at most the length, the quotient fits QW bits.
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [CW-1:0] dv;
    logic          gex;
    logic          gey;

    assign dv  = CW'(len_d[j]) << B;
    assign gex = rx_d[j] >= dv;
    assign gey = ry_d[j] >= dv;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd[j+1] <= 1'b0;
      end else if (adv) begin
        vd[j+1] <= vd[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        len_d[j+1] <= len_d[j];
        rx_d[j+1]  <= gex ? (rx_d[j] - dv) : rx_d[j];
        ry_d[j+1]  <= gey ? (ry_d[j] - dv) : ry_d[j];
        qx_d[j+1]  <= gex ? (qx_d[j] | (QW'(1) << B)) : qx_d[j];
        qy_d[j+1]  <= gey ? (qy_d[j] | (QW'(1) << B)) : qy_d[j];
        tag_d[j+1] <= tag_d[j];
      end
    end
  end

  assign out_valid = vd[QW];
  assign out_len   = len_d[QW];
  assign out_qx    = qx_d[QW];
  assign out_qy    = qy_d[QW];
  assign out_tag   = tag_d[QW];

endmodule

[rtl/dsf_checker.sv]
// Port-level checks of the damped spring force block, bound to its top level.
// Uses dsf_pkg and damped_spring_force_2d_macros.svh.
`include "damped_spring_force_2d_macros.svh"

module dsf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input dsf_pkg::dsf_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input dsf_pkg::dsf_out_t out_data
);
  import dsf_pkg::*;

  // A waiting input keeps its payload until its transfer.
  `DSF_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "input changed while waiting")

  // A stalled result stays put until its transfer.
  `DSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // The input side stalls only behind a stalled result.
  `DSF_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

  // Coincident ends give the direction (1,0), so no y force.
  `DSF_ASSERT_NOW(a_zero_len_y, out_valid && out_data.zero_length, out_data.force_y == 32'sd0, "force y nonzero at zero length")

endmodule

bind damped_spring_force_2d dsf_checker u_dsf_checker (.*);

[test/testbench.sv]
// Self-checking bench for damped_spring_force_2d: a directed stimulus table and then
// random spring evaluations, each result checked against a fixed point force predictor
// or a typed table result. Depends on dsf_pkg and the damped_spring_force_2d RTL.
module testbench;
  import dsf_pkg::*;

  localparam int LAT_WAIT   = 70;
  localparam int STALL_STOP = 4000;

  typedef struct {
    dsf_in_t  stim;
    bit       typed;
    dsf_out_t res;
  } spring_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  dsf_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  dsf_out_t   out_data;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = CFG_REST_LENGTH;
  logic [31:0] cfg_wdata = '0;

  // Register copies used by the force predictor.
  logic [30:0] rest_q = REST_RESET;
  logic [31:0] stiff_q = STIFF_RESET;
  logic [31:0] damp_q = DAMP_RESET;

  bit       cur_typed = 1'b0;
  dsf_out_t cur_force = '0;
  bit       calm = 1'b0;
  dsf_out_t pending_forces[$];
  spring_row_t rows[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       springs_sent = 0;
  int       forces_seen = 0;
  int       stall_left = 0;

  damped_spring_force_2d dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] force_part(bit sneg, logic [127:0] smag, longint u,
                                             output bit clipped);
    logic [127:0] f;
    logic [127:0] lim;
    logic [127:0] m;
    bit neg;
    f = (smag * 128'(u < 0 ? -u : u)) >> FRAC;
    neg = (sneg != (u < 0)) && (f != 0);
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    clipped = f > lim;
    m = clipped ? lim : f;
    return neg ? 32'(-m[31:0]) : m[31:0];
  endfunction

  // Force on the first end, exact integer arithmetic with truncation toward zero.
  function automatic dsf_out_t spring_force(dsf_in_t s);
    longint dx, dy, rvx, rvy, ux, uy, vel, stretch;
    logic [127:0] ax, ay, sq, root, c, tk, td, sum;
    bit tkn, tdn, sn, c0, c1;
    dsf_out_t r;
    dx  = longint'(s.second_pos_x) - longint'(s.first_pos_x);
    dy  = longint'(s.second_pos_y) - longint'(s.first_pos_y);
    rvx = longint'(s.second_vel_x) - longint'(s.first_vel_x);
    rvy = longint'(s.second_vel_y) - longint'(s.first_vel_y);
    ax = 128'(dx < 0 ? -dx : dx);
    ay = 128'(dy < 0 ? -dy : dy);
    sq = ax * ax + ay * ay;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      c = root | (128'd1 << b);
      if (c * c <= sq) root = c;
    end
    r = '0;
    if (root == 0) begin
      ux = longint'(1) << FRAC;
      uy = 0;
      r.zero_length = 1'b1;
    end else begin
      ux = longint'(((ax << FRAC) / root));
      uy = longint'(((ay << FRAC) / root));
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
    end
    vel = ux * rvx + uy * rvy;
    vel = vel < 0 ? -((-vel) >> FRAC) : (vel >> FRAC);
    stretch = longint'(root[63:0]) - longint'({33'd0, rest_q});
    tk = 128'(stretch < 0 ? -stretch : stretch) * 128'(stiff_q);
    td = 128'(vel < 0 ? -vel : vel) * 128'(damp_q);
    tkn = stretch < 0;
    tdn = vel < 0;
    if (tkn == tdn) begin
      sum = tk + td;
      sn = tkn;
    end else if (tk < td) begin
      sum = td - tk;
      sn = tdn;
    end else begin
      sum = tk - td;
      sn = tkn;
    end
    sum = {64'd0, sum[FRAC +: 64]};
    r.force_x = force_part(sn, sum, ux, c0);
    r.force_y = force_part(sn, sum, uy, c1);
    r.saturated = c0 | c1;
    return r;
  endfunction

  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_forces.push_back(cur_typed ? cur_force : spring_force(in_data));
        springs_sent++;
      end
      if (out_valid && out_ready) begin
        forces_seen++;
        if (pending_forces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected force result %p", out_data);
        end else begin
          dsf_out_t want;
          want = pending_forces.pop_front();
          if (want !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected fx=%0d fy=%0d zl=%0b sat=%0b, got %0d %0d %0b %0b",
                       want.force_x, want.force_y, want.zero_length, want.saturated,
                       out_data.force_x, out_data.force_y, out_data.zero_length,
                       out_data.saturated);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_STOP) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_spring(dsf_in_t d, bit typed, dsf_out_t e);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    cur_typed <= typed;
    cur_force <= e;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_forces.size() != 0) @(negedge clk);
    repeat (LAT_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(dsf_cfg_idx_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_REST_LENGTH: rest_q = val[30:0];
      CFG_STIFFNESS:   stiff_q = val;
      default:         damp_q = val;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] small_q;
    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  function automatic dsf_in_t random_spring;
    dsf_in_t d;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    d = {small_q(), small_q(), small_q(), small_q(),
         small_q(), small_q(), small_q(), small_q()};
    case (mode)
      6: d = {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      7: begin
        d.second_pos_x = d.first_pos_x;
        d.second_pos_y = d.first_pos_y;
      end
      8: begin
        d.first_vel_x = '0;  d.first_vel_y = '0;
        d.second_vel_x = '0; d.second_vel_y = '0;
      end
      9: d.second_pos_y = d.first_pos_y;
      default: ;
    endcase
    return d;
  endfunction

  task automatic add_row(logic [31:0] fx, logic [31:0] fy, logic [31:0] sx, logic [31:0] sy,
                         logic [31:0] fvx, logic [31:0] fvy, logic [31:0] svx,
                         logic [31:0] svy, bit typed, dsf_out_t res);
    spring_row_t row;
    row.stim = {fx, fy, sx, sy, fvx, fvy, svx, svy};
    row.typed = typed;
    row.res = res;
    rows.push_back(row);
  endtask

  task automatic random_phase(int n);
    repeat (n) send_spring(random_spring(), 1'b0, '0);
    drain();
  endtask

  initial begin
    localparam logic [31:0] MAXI = 32'h7fff_ffff;
    localparam logic [31:0] MINI = 32'h8000_0000;
    // Coincident ends at rest: direction defaults to x and the compressed spring pushes toward -x.
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '{-32'sd2621440, 0, 1'b1, 1'b0});
    add_row(0, 0, 32'h2_0000, 0, 0, 0, 0, 0, 1'b1, '{32'sd2621440, 0, 1'b0, 1'b0});
    add_row(0, 0, 0, 32'h3_0000, 0, 0, 0, 0, 1'b1, '{0, 32'sd5242880, 1'b0, 1'b0});
    add_row(0, 0, 0, 32'hfffd_0000, 0, 0, 0, 0, 1'b0, '0);
    add_row(MINI, MINI, MAXI, MAXI, 0, 0, 0, 0, 1'b0, '0);
    add_row(MAXI, MAXI, MINI, MINI, MINI, MINI, MAXI, MAXI, 1'b0, '0);
    add_row(MINI, 0, MAXI, 0, MAXI, MAXI, MINI, MINI, 1'b0, '0);
    add_row(5, 7, 5, 7, 32'h1_0000, 0, MAXI, MINI, 1'b0, '0);
    add_row(MAXI, MINI, MAXI, MINI, MINI, MAXI, MAXI, MINI, 1'b0, '0);
    add_row(0, 0, 1, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(0, 0, 32'h3_0000, 32'h4_0000, 32'h1_0000, 0, 0, 32'h2_0000, 1'b0, '0);
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 1, 1'b0, '0);
    add_row(0, 0, 32'h0_8000, 0, 0, 0, 32'h7fff_0000, 0, 1'b0, '0);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_spring(rows[i].stim, rows[i].typed, rows[i].res);
    random_phase(220);

    write_reg(CFG_REST_LENGTH, 32'd0);
    write_reg(CFG_STIFFNESS, 32'hffff_ffff);
    write_reg(CFG_DAMPING, 32'hffff_ffff);
    foreach (rows[i]) send_spring(rows[i].stim, 1'b0, '0);
    random_phase(220);

    write_reg(CFG_REST_LENGTH, 32'h7fff_ffff);
    write_reg(CFG_STIFFNESS, 32'd0);
    write_reg(CFG_DAMPING, 32'd0);
    random_phase(220);

    write_reg(CFG_REST_LENGTH, $urandom >> $urandom_range(1, 21));
    write_reg(CFG_STIFFNESS, $urandom >> $urandom_range(0, 24));
    write_reg(CFG_DAMPING, $urandom >> $urandom_range(0, 24));
    random_phase(220);

    // Last stretch runs at full rate on both sides.
    write_reg(CFG_REST_LENGTH, 32'(REST_RESET));
    write_reg(CFG_STIFFNESS, STIFF_RESET);
    write_reg(CFG_DAMPING, DAMP_RESET);
    calm = 1'b1;
    random_phase(250);

    $display("Checked %0d force results from %0d springs over five register settings,",
             forces_seen, springs_sent);
    $display("including coincident ends, full-range coordinates and saturating coefficients.");
    if (mismatches == 0 && pending_forces.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/dsf_pkg.sv
rtl/dsf_root_div.sv
rtl/damped_spring_force_2d.sv
rtl/dsf_checker.sv
test/testbench.sv
